### rtl/bdlp_pkg.sv
// Shared types, register indexes, event codes and reset values of the button debouncer.
package bdlp_pkg;

  localparam int unsigned TimeBitsDefault = 32;
  localparam int unsigned NowWidth        = 32;
  localparam int unsigned MsWidth         = 31;
  localparam int unsigned CfgIdxWidth     = 3;
  localparam int unsigned CfgDataWidth    = 32;

  localparam logic [MsWidth-1:0] DebounceMsReset  = MsWidth'(50);
  localparam logic [MsWidth-1:0] LongPressMsReset = MsWidth'(1000);

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_PRESS = 2'd1,
    EV_SHORT = 2'd2,
    EV_LONG  = 2'd3
  } event_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_DEBOUNCE_MS   = 3'd0,
    REG_LONG_PRESS_MS = 3'd1,
    REG_PRESS_EN      = 3'd2,
    REG_SHORT_REL_EN  = 3'd3,
    REG_LONG_REL_EN   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [MsWidth-1:0] debounce_ms;
    logic [MsWidth-1:0] long_press_ms;
    logic               press_en;
    logic               short_rel_en;
    logic               long_rel_en;
  } cfg_t;

endpackage

### rtl/button_debounce_long_press.sv
// Active-low push-button debouncer with press, short-release and long-release events.
// An accepted sample reaches its result through the input register and then the result
// register. Throughput: one sample per cycle, with ready passed back
// through both stages. Reset puts the block in the released state with empty stages
// and the register defaults (50 ms settle, 1000 ms long press, all events enabled).
module button_debounce_long_press #(
  parameter int unsigned TIME_BITS = bdlp_pkg::TimeBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bdlp_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [bdlp_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              raw_level_i,
  input  logic [bdlp_pkg::NowWidth-1:0]     now_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        event_res_o,
  output logic                              stable_level_o
);
  import bdlp_pkg::*;

  cfg_t                 cfg;
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_raw_q;
  logic [TIME_BITS-1:0] s1_now_q;
  logic                 out_valid_q, out_valid_d;
  event_e               ev_q;
  logic                 level_q;
  logic                 s1_ready;
  logic                 s2_ready;
  logic                 step;
  event_e               core_ev;
  logic                 core_level;

  bdlp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bdlp_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .step_i         (step),
    .raw_level_i    (s1_raw_q),
    .now_i          (s1_now_q),
    .event_o        (core_ev),
    .stable_level_o (core_level)
  );

  assign s2_ready    = !out_valid_q || out_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign step        = s1_valid_q && s2_ready;
  assign in_ready_o  = s1_ready;
  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = ev_q;
  assign stable_level_o = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_raw_q <= raw_level_i;
      s1_now_q <= TIME_BITS'(now_ms_i);
    end
    if (step) begin
      ev_q    <= core_ev;
      level_q <= core_level;
    end
  end

endmodule

### rtl/bdlp_cfg.sv
// Configuration register file of the button debouncer.
module bdlp_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bdlp_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [bdlp_pkg::CfgDataWidth-1:0] cfg_data_i,
  output bdlp_pkg::cfg_t                    cfg_o
);
  import bdlp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DEBOUNCE_MS:   cfg_d.debounce_ms   = cfg_data_i[MsWidth-1:0];
        REG_LONG_PRESS_MS: cfg_d.long_press_ms = cfg_data_i[MsWidth-1:0];
        REG_PRESS_EN:      cfg_d.press_en      = cfg_data_i[0];
        REG_SHORT_REL_EN:  cfg_d.short_rel_en  = cfg_data_i[0];
        REG_LONG_REL_EN:   cfg_d.long_rel_en   = cfg_data_i[0];
        default:           cfg_d               = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceMsReset;
      cfg_q.long_press_ms <= LongPressMsReset;
      cfg_q.press_en      <= 1'b1;
      cfg_q.short_rel_en  <= 1'b1;
      cfg_q.long_rel_en   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/bdlp_core.sv
// Debounce state and per-sample next-state and event logic.
module bdlp_core #(
  parameter int unsigned TIME_BITS = bdlp_pkg::TimeBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bdlp_pkg::cfg_t         cfg_i,
  input  logic                   step_i,
  input  logic                   raw_level_i,
  input  logic [TIME_BITS-1:0]   now_i,
  output bdlp_pkg::event_e       event_o,
  output logic                   stable_level_o
);
  import bdlp_pkg::*;

  localparam int unsigned CmpWidth = (TIME_BITS > MsWidth) ? TIME_BITS : MsWidth;

  logic                 prev_q, prev_d;
  logic                 deb_q, deb_d;
  logic [TIME_BITS-1:0] last_chg_q, last_chg_d;
  logic [TIME_BITS-1:0] trans_q, trans_d;
  logic [TIME_BITS-1:0] settle_time;
  logic [TIME_BITS-1:0] held_time;
  logic                 accept;
  logic                 is_short;

  always_comb begin
    last_chg_d  = (raw_level_i != prev_q) ? now_i : last_chg_q;
    settle_time = now_i - last_chg_d;
    held_time   = now_i - trans_q;
    accept      = (CmpWidth'(settle_time) > CmpWidth'(cfg_i.debounce_ms))
                  && (deb_q != raw_level_i);
    is_short    = CmpWidth'(held_time) < CmpWidth'(cfg_i.long_press_ms);

    event_o = EV_NONE;
    if (accept) begin
      if (!raw_level_i) begin
        if (cfg_i.press_en) begin
          event_o = EV_PRESS;
        end
      end else begin
        priority if (is_short && cfg_i.short_rel_en) begin
          event_o = EV_SHORT;
        end else if (cfg_i.long_rel_en) begin
          event_o = EV_LONG;
        end else begin
          event_o = EV_NONE;
        end
      end
    end

    prev_d         = raw_level_i;
    deb_d          = accept ? raw_level_i : deb_q;
    trans_d        = accept ? now_i : trans_q;
    stable_level_o = deb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b1;
      deb_q      <= 1'b1;
      last_chg_q <= '0;
      trans_q    <= '0;
    end else if (step_i) begin
      prev_q     <= prev_d;
      deb_q      <= deb_d;
      last_chg_q <= last_chg_d;
      trans_q    <= trans_d;
    end
  end

endmodule
